### rtl/spr_pkg.sv
`timescale 1ns / 1ps

package spr_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int PAGE_BITS_DEF  = 12;

    localparam int ADDR_W = 32;
    localparam int PAGE_W = 20;
    localparam int SLOT_W = 6;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0] start_page;
        logic [PAGE_W-1:0] end_page;
    } t_entry;

    // strobes broadcast to every cell on an accepted beat
    typedef struct packed {
        logic load;
        logic lookup;
        logic insert;
    } t_cmd;

endpackage

### rtl/spr_cell.sv
`timescale 1ns / 1ps

module spr_cell
    import spr_pkg::*;
#(
    parameter int CMP_W = PAGE_W
) (
    input  logic             i_clk,
    input  logic             i_valid_slot,
    input  t_cmd             i_cmd,
    input  logic [CMP_W-1:0] i_page,
    input  t_entry           i_new,
    input  t_entry           i_left,
    input  logic             i_left_lt,
    input  logic             i_right_le,
    output t_entry           o_entry,
    output logic             o_lt,
    output logic             o_le,
    output logic             o_flag,
    output logic             o_hit
);

    t_entry r_entry;
    logic   r_flag;
    logic   r_hit;
    logic   w_take_new;
    logic   w_sel;

    assign o_lt = i_valid_slot && (r_entry.start_page < i_new.start_page);
    assign o_le = i_valid_slot && (CMP_W'(r_entry.start_page) <= i_page);

    // first cell not below the new start takes it, later cells take the left neighbor
    assign w_take_new = !o_lt && i_left_lt;
    // last stored range starting at or below the page
    assign w_sel      = o_le && !i_right_le;

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !o_lt) begin
            r_entry <= w_take_new ? i_new : i_left;
        end
        if (i_cmd.load) begin
            r_flag <= i_cmd.lookup ? w_sel : (i_cmd.insert && w_take_new);
            r_hit  <= i_cmd.lookup && w_sel && (i_page < CMP_W'(r_entry.end_page));
        end
    end

    assign o_entry = r_entry;
    assign o_flag  = r_flag;
    assign o_hit   = r_hit;

endmodule

### rtl/spr_enc.sv
`timescale 1ns / 1ps

module spr_enc
    import spr_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic [MAX_RANGES-1:0] i_flag,
    input  logic [MAX_RANGES-1:0] i_hit,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_hit
);

    localparam int IW = $clog2(MAX_RANGES);

    logic [IW-1:0] w_idx;

    // at most one flag is set, so or-ing the indexes encodes it
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            if (i_flag[i]) begin
                w_idx = w_idx | IW'(i);
            end
        end
    end

    for (genvar b = 0; b < SLOT_W; b++) begin : g_slot
        if (b < IW) begin : g_on
            assign o_slot[b] = w_idx[b];
        end else begin : g_off
            assign o_slot[b] = 1'b0;
        end
    end

    assign o_hit = |i_hit;

endmodule

### rtl/sorted_page_range_table_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// request   in         i_valid / o_ready   i_mode, i_address, i_range_start_page,
//                                          i_range_end_page
// result    out        o_valid / i_ready   o_hit, o_slot, o_table_full
//
// one beat per cycle sustained while results are taken; every cell compares in parallel at the accept edge
// result is registered twice after its request beat (cell flags, then output register)
// an insert shifts the cell chain by one at its accept edge, seen by the next beat
// reset (synchronous, active low) empties the table and drops any beat in flight
// a stalled result holds the cell stage; new requests wait only when both are full

module sorted_page_range_table_top
    import spr_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [PAGE_W-1:0] i_range_start_page,
    input  logic [PAGE_W-1:0] i_range_end_page,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_hit,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_table_full
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int PG_W  = ADDR_W - PAGE_BITS;
    localparam int CMP_W = (PG_W > PAGE_W) ? PG_W : PAGE_W;

    logic [CNT_W-1:0]      r_count;
    logic                  r_s1_valid;
    logic                  r_s1_full;
    logic                  r_o_valid;
    logic                  r_o_hit;
    logic [SLOT_W-1:0]     r_o_slot;
    logic                  r_o_full;

    logic                  w_accept;
    logic                  w_adv;
    logic                  w_full;
    t_cmd                  w_cmd;
    t_entry                w_new;
    logic [CMP_W-1:0]      w_page;
    t_entry                w_entry [MAX_RANGES];
    logic [MAX_RANGES-1:0] w_lt;
    logic [MAX_RANGES:0]   w_le;
    logic [MAX_RANGES-1:0] w_valid_slot;
    logic [MAX_RANGES-1:0] w_flag;
    logic [MAX_RANGES-1:0] w_hit_bits;
    logic [SLOT_W-1:0]     w_enc_slot;
    logic                  w_enc_hit;

    assign w_adv    = !r_o_valid || i_ready;
    assign o_ready  = !r_s1_valid || w_adv;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(MAX_RANGES));

    assign w_cmd.load   = w_accept;
    assign w_cmd.lookup = w_accept && (i_mode == MODE_LOOKUP);
    assign w_cmd.insert = w_accept && (i_mode == MODE_INSERT) && !w_full;

    assign w_new.start_page = i_range_start_page;
    assign w_new.end_page   = i_range_end_page;
    assign w_page           = CMP_W'(i_address[ADDR_W-1:PAGE_BITS]);

    assign w_le[MAX_RANGES] = 1'b0;

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        assign w_valid_slot[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            spr_cell #(
                .CMP_W(CMP_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_valid_slot(w_valid_slot[g]),
                .i_cmd       (w_cmd),
                .i_page      (w_page),
                .i_new       (w_new),
                .i_left      (w_new),
                .i_left_lt   (1'b1),
                .i_right_le  (w_le[g+1]),
                .o_entry     (w_entry[g]),
                .o_lt        (w_lt[g]),
                .o_le        (w_le[g]),
                .o_flag      (w_flag[g]),
                .o_hit       (w_hit_bits[g])
            );
        end else begin : g_body
            spr_cell #(
                .CMP_W(CMP_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_valid_slot(w_valid_slot[g]),
                .i_cmd       (w_cmd),
                .i_page      (w_page),
                .i_new       (w_new),
                .i_left      (w_entry[g-1]),
                .i_left_lt   (w_lt[g-1]),
                .i_right_le  (w_le[g+1]),
                .o_entry     (w_entry[g]),
                .o_lt        (w_lt[g]),
                .o_le        (w_le[g]),
                .o_flag      (w_flag[g]),
                .o_hit       (w_hit_bits[g])
            );
        end
    end

    spr_enc #(
        .MAX_RANGES(MAX_RANGES)
    ) u_enc (
        .i_flag(w_flag),
        .i_hit (w_hit_bits),
        .o_slot(w_enc_slot),
        .o_hit (w_enc_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_cmd.insert) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_full <= (i_mode == MODE_INSERT) && w_full;
        end
        if (w_adv && r_s1_valid) begin
            r_o_hit  <= w_enc_hit;
            r_o_slot <= w_enc_slot;
            r_o_full <= r_s1_full;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_hit        = r_o_hit;
    assign o_slot       = r_o_slot;
    assign o_table_full = r_o_full;

endmodule

### rtl/spr_checker.sv
`timescale 1ns / 1ps

module spr_checker
    import spr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_mode,
    input logic [ADDR_W-1:0] i_address,
    input logic [PAGE_W-1:0] i_range_start_page,
    input logic [PAGE_W-1:0] i_range_end_page,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_hit,
    input logic [SLOT_W-1:0] o_slot,
    input logic              o_table_full
);

    // a refused insert never reports a hit
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_table_full))
        else $error("hit and table_full set on the same beat");

    // a refused insert reports slot zero
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_slot == '0))
        else $error("refused insert with nonzero slot");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit) && $stable(o_slot)
            && $stable(o_table_full)))
        else $error("stalled result beat changed");

endmodule

bind sorted_page_range_table_top spr_checker u_spr_checker (.*);
